// ----- hw/rtl/sdmps_pkg.sv -----
// Shared types and constants for the multiplexed segment display driver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdmps_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned EN_W      = 2;
  localparam int unsigned OFF_W     = 7;
  localparam int unsigned TIMER_W   = 10;
  localparam int unsigned BLINK_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [BLINK_W-1:0] BLINK_HALF     = 8'd128;
  localparam logic [CHAR_W-1:0]  SPACE_CODE     = 8'd32;
  localparam logic [DATA_W-1:0]  BRIGHT_RST     = 16'hFFFF;
  localparam logic [TIMER_W-1:0] STEP_DELAY_RST = 10'd180;
  localparam logic [TIMER_W-1:0] PRE_DELAY_RST  = 10'd600;

  // brightness rescale: a' = 2^(16-R) + (2^R - 1) * (a >> R)
  localparam int unsigned RATIO_BITS = 5;
  localparam logic [16:0] FADE_BIAS  = 17'd16384;
  localparam logic [16:0] RATIO_BIAS = 17'd2048;
  localparam logic [16:0] RATIO_MUL  = 17'd31;

  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_PTR_W = 3;
  localparam int unsigned OFIFO_CNT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_FAST_TICK  = 3'd0,
    OP_SLOW_TICK  = 3'd1,
    OP_SHORT_CHAR = 3'd2,
    OP_LONG_CHAR  = 3'd3,
    OP_COMMIT     = 3'd4,
    OP_SCROLL     = 3'd5,
    OP_MASK_WORD  = 3'd6,
    OP_FONT_ENTRY = 3'd7
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 3'd0,
    CFG_BLINK      = 3'd1,
    CFG_FADE_STEP  = 3'd2,
    CFG_STEP_DELAY = 3'd3,
    CFG_PRE_DELAY  = 3'd4
  } cfg_e;

  // one accepted item on its way to the font lookup
  typedef struct packed {
    logic                tick;
    logic                load;
    logic                mask_sel;
    logic [DATA_W-1:0]   mask_word;
    logic                show_long;
    logic                in_range;
    logic [CHAR_W-1:0]   short_char;
    logic [EN_W-1:0]     enables;
    logic                font_we;
    logic [IDX_W-1:0]    font_addr;
    logic [DATA_W-1:0]   font_data;
  } req_t;

  typedef struct packed {
    logic [EN_W-1:0]   enables;
    logic              load;
    logic [DATA_W-1:0] word;
  } out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/segment_display_mux_pwm_scroll.sv -----
// Multiplexed 14-segment display driver with PWM dimming, blink, fade and scrolling.
// Top level: uses sdmps_pkg, sdmps_ctrl, sdmps_text, sdmps_font, sdmps_ofifo.
//
// One item (tick or write) is taken per clock. Every fast tick gives one result,
// registered in turn through the long text memory read, then the font memory
// read, then the result queue. Other items give no result. The input
// stalls only when the 8-entry result queue plus the ticks still in the two
// lookup stages would fill it, so a waiting result does not hold up the input.
// The long text starts as spaces through per-entry valid bits, with no clearing
// pass after reset. Font entries and mask words are undefined until written.
`default_nettype none

module segment_display_mux_pwm_scroll import sdmps_pkg::*; #(
  parameter int unsigned DIGITS       = 2,
  parameter int unsigned SCROLL_CHARS = 64,
  parameter int unsigned PWM_BITS     = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // [7:0] index, [23:8] value
  input  wire logic [OP_W-1:0]      s_axis_tuser,  // [2:0] opcode
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // [1:0] digit_enables, [17:2] segment_word
  output logic [0:0]                m_axis_tuser,  // [0] segment_load
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned AW = $clog2(SCROLL_CHARS);
  localparam int unsigned LW = $clog2(SCROLL_CHARS + 1);

  logic                   in_xfer;
  req_t                   req0, req1;
  logic                   lt_we;
  logic [AW-1:0]          lt_waddr, lt_raddr;
  logic [CHAR_W-1:0]      lt_wdata, char1;
  logic                   res_valid;
  out_t                   res, head;
  logic                   pop;
  logic [OFIFO_CNT_W-1:0] q_cnt;
  logic [OFIFO_CNT_W:0]   q_claim;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // reserve queue room for ticks still in the lookup stages
  assign q_claim       = {1'b0, q_cnt} + (OFIFO_CNT_W+1)'(req1.tick)
                         + (OFIFO_CNT_W+1)'(res_valid);
  assign s_axis_tready = q_claim < (OFIFO_CNT_W+1)'(OFIFO_DEPTH);

  sdmps_ctrl #(
    .DIGITS       (DIGITS),
    .SCROLL_CHARS (SCROLL_CHARS),
    .PWM_BITS     (PWM_BITS),
    .PW           (PW),
    .AW           (AW),
    .LW           (LW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .op_i        (op_e'(s_axis_tuser)),
    .idx_i       (s_axis_tdata[7:0]),
    .val_i       (s_axis_tdata[23:8]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_o       (req0),
    .lt_we_o     (lt_we),
    .lt_waddr_o  (lt_waddr),
    .lt_wdata_o  (lt_wdata),
    .lt_raddr_o  (lt_raddr)
  );

  sdmps_text #(
    .SCROLL_CHARS (SCROLL_CHARS),
    .AW           (AW)
  ) u_text (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req0),
    .lt_we_i    (lt_we),
    .lt_waddr_i (lt_waddr),
    .lt_wdata_i (lt_wdata),
    .lt_raddr_i (lt_raddr),
    .req_o      (req1),
    .char_o     (char1)
  );

  sdmps_font u_font (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req1),
    .char_i      (char1),
    .out_valid_o (res_valid),
    .out_o       (res)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  sdmps_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (m_axis_tvalid),
    .data_o  (head),
    .count_o (q_cnt)
  );

  assign m_axis_tdata = {6'b0, head.word, head.enables};
  assign m_axis_tuser = head.load;

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid && (q_cnt == OFIFO_CNT_W'(OFIFO_DEPTH)) && !pop))
    else $error("result queue overflow");

  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tuser == OP_FAST_TICK)) |-> ##2 res_valid)
    else $error("fast tick lost in lookup stages");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> $past(in_xfer && (s_axis_tuser == OP_FAST_TICK), 2))
    else $error("result without a fast tick");

  a_blank_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[17:2] == '0))
    else $error("segment word set without load");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sdmps_ctrl.sv -----
// Control state: config registers, PWM/position stepping, scroll timers, fade and blink.
// Uses sdmps_pkg. Produces the per-item request and the long text memory port.
`default_nettype none

module sdmps_ctrl import sdmps_pkg::*; #(
  parameter int unsigned DIGITS       = 2,
  parameter int unsigned SCROLL_CHARS = 64,
  parameter int unsigned PWM_BITS     = 6,
  parameter int unsigned PW           = 1,
  parameter int unsigned AW           = 6,
  parameter int unsigned LW           = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire op_e                  op_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  input  wire logic [DATA_W-1:0]    val_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  output req_t                      req_o,
  output logic                      lt_we_o,
  output logic [AW-1:0]             lt_waddr_o,
  output logic [CHAR_W-1:0]         lt_wdata_o,
  output logic [AW-1:0]             lt_raddr_o
);

  logic [DATA_W-1:0]  bright_q, fade_step_q;
  logic               blink_en_q;
  logic [TIMER_W-1:0] step_dly_q, pre_dly_q;

  logic [PW-1:0]       pos_q, pos_d, pos_nxt;
  logic [PWM_BITS-1:0] phase_q, phase_d, duty_q, duty_d;
  logic [DIGITS-1:0]   redraw_q, redraw_d, en_q, en_d;
  logic [BLINK_W-1:0]  blink_q, blink_d;
  logic [DATA_W-1:0]   fade_q, fade_d;
  logic                act_q, act_d, show_q, show_d, mask_mode_q, mask_mode_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [TIMER_W-1:0]  step_q, step_d, pre_q, pre_d;
  logic [LW-1:0]       len_q, len_d;
  logic [CHAR_W-1:0]   short_q [DIGITS];
  logic [CHAR_W-1:0]   short_d [DIGITS];
  logic [DATA_W-1:0]   mask_q [DIGITS];

  logic                lit;
  logic [16:0]         a_lvl, a_dim;
  logic [7:0]          lt_sum;
  logic [DIGITS+1:0]   en_pad;

  assign pos_nxt = (pos_q == PW'(DIGITS - 1)) ? '0 : pos_q + PW'(1);
  assign en_pad  = {2'b00, en_d};

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= BRIGHT_RST;
      blink_en_q  <= 1'b0;
      fade_step_q <= '0;
      step_dly_q  <= STEP_DELAY_RST;
      pre_dly_q   <= PRE_DELAY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BRIGHTNESS: bright_q    <= cfg_data_i;
        CFG_BLINK:      blink_en_q  <= cfg_data_i[0];
        CFG_FADE_STEP:  fade_step_q <= cfg_data_i;
        CFG_STEP_DELAY: step_dly_q  <= cfg_data_i[TIMER_W-1:0];
        CFG_PRE_DELAY:  pre_dly_q   <= cfg_data_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    redraw_d    = redraw_q;
    en_d        = en_q;
    duty_d      = duty_q;
    blink_d     = blink_q;
    fade_d      = fade_q;
    act_d       = act_q;
    show_d      = show_q;
    mask_mode_d = mask_mode_q;
    off_d       = off_q;
    step_d      = step_q;
    pre_d       = pre_q;
    len_d       = len_q;
    short_d     = short_q;
    lit         = 1'b0;
    a_lvl       = '0;
    a_dim       = '0;
    lt_sum      = '0;
    req_o       = '0;
    lt_we_o     = 1'b0;
    lt_waddr_o  = idx_i[AW-1:0];
    lt_wdata_o  = val_i[CHAR_W-1:0];

    if (in_valid_i) begin
      case (op_i)
        OP_FAST_TICK: begin
          if (phase_q == '0) begin
            en_d[pos_q]      = 1'b0;
            pos_d            = pos_nxt;
            redraw_d[pos_nxt] = 1'b1;
          end else if (phase_q - PWM_BITS'(1) == duty_q) begin
            redraw_d[pos_q] = 1'b1;
          end
          lit = (phase_q <= duty_q) && (!blink_en_q || (blink_q < BLINK_HALF));
          if (redraw_d[pos_d]) begin
            redraw_d[pos_d] = 1'b0;
            en_d[pos_d]     = lit;
            req_o.load      = lit;
          end
          phase_d          = phase_q + PWM_BITS'(1);
          lt_sum           = {1'b0, off_q} + 8'(pos_d);
          req_o.tick       = 1'b1;
          req_o.mask_sel   = mask_mode_q;
          req_o.mask_word  = mask_q[pos_d];
          req_o.show_long  = show_q;
          req_o.in_range   = lt_sum < 8'(SCROLL_CHARS);
          req_o.short_char = short_q[pos_d];
          req_o.enables    = en_pad[EN_W-1:0];
        end
        OP_SLOW_TICK: begin
          if (act_q) begin
            if (pre_q != '0) begin
              pre_d = pre_q - TIMER_W'(1);
            end else begin
              step_d = step_q - TIMER_W'(1);
              if (step_d == '0) begin
                off_d = off_q + OFF_W'(1);
                // stop once the window has run past the end of the text
                if ((9'(off_d) + 9'(DIGITS)) > (9'(len_q) + 9'd1)) begin
                  act_d = 1'b0;
                end
                step_d = step_dly_q;
              end
            end
          end
          show_d = act_d && (pre_d == '0);
          if (fade_step_q != '0) begin
            fade_d = fade_q + fade_step_q;
            a_lvl  = 17'(fade_d >> 1) + 17'(fade_d >> 2) + FADE_BIAS;
          end else begin
            a_lvl = {1'b0, bright_q};
          end
          a_dim    = RATIO_BIAS + RATIO_MUL * (a_lvl >> RATIO_BITS);
          duty_d   = a_dim[15 -: PWM_BITS];
          blink_d  = blink_q + BLINK_W'(1);
          redraw_d = '1;
        end
        OP_SHORT_CHAR: begin
          if (idx_i < 8'(DIGITS)) begin
            short_d[idx_i[PW-1:0]] = val_i[CHAR_W-1:0];
          end
        end
        OP_LONG_CHAR: begin
          lt_we_o = idx_i < 8'(SCROLL_CHARS);
        end
        OP_COMMIT: begin
          len_d       = (val_i < 16'(SCROLL_CHARS)) ? LW'(val_i) : LW'(SCROLL_CHARS);
          act_d       = 1'b0;
          mask_mode_d = 1'b0;
        end
        OP_SCROLL: begin
          if (8'(len_q) > 8'(DIGITS)) begin
            act_d  = 1'b1;
            off_d  = '0;
            step_d = step_dly_q;
            pre_d  = pre_dly_q;
          end
        end
        OP_MASK_WORD: begin
          if (idx_i < 8'(DIGITS)) begin
            mask_mode_d = 1'b1;
          end
        end
        OP_FONT_ENTRY: begin
          req_o.font_we   = 1'b1;
          req_o.font_addr = idx_i;
          req_o.font_data = val_i;
        end
        default: ;
      endcase
    end
  end

  assign lt_raddr_o = lt_sum[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= '0;
      redraw_q    <= '0;
      en_q        <= '0;
      duty_q      <= '0;
      blink_q     <= '0;
      fade_q      <= '0;
      act_q       <= 1'b0;
      show_q      <= 1'b0;
      mask_mode_q <= 1'b0;
      off_q       <= '0;
      step_q      <= '0;
      pre_q       <= '0;
      len_q       <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        short_q[i] <= SPACE_CODE;
      end
    end else begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      redraw_q    <= redraw_d;
      en_q        <= en_d;
      duty_q      <= duty_d;
      blink_q     <= blink_d;
      fade_q      <= fade_d;
      act_q       <= act_d;
      show_q      <= show_d;
      mask_mode_q <= mask_mode_d;
      off_q       <= off_d;
      step_q      <= step_d;
      pre_q       <= pre_d;
      len_q       <= len_d;
      short_q     <= short_d;
    end
  end

  // mask words hold no reset value
  always_ff @(posedge clk_i) begin
    if (in_valid_i && (op_i == OP_MASK_WORD) && (idx_i < 8'(DIGITS))) begin
      mask_q[idx_i[PW-1:0]] <= val_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sdmps_text.sv -----
// Long text memory with per-entry valid bits (unwritten entries read as space).
// Uses sdmps_pkg. Registers the request alongside the memory read.
`default_nettype none

module sdmps_text import sdmps_pkg::*; #(
  parameter int unsigned SCROLL_CHARS = 64,
  parameter int unsigned AW           = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire req_t              req_i,
  input  wire logic              lt_we_i,
  input  wire logic [AW-1:0]     lt_waddr_i,
  input  wire logic [CHAR_W-1:0] lt_wdata_i,
  input  wire logic [AW-1:0]     lt_raddr_i,
  output req_t                   req_o,
  output logic [CHAR_W-1:0]      char_o
);

  logic [CHAR_W-1:0]       lt_mem [SCROLL_CHARS];
  logic [SCROLL_CHARS-1:0] lt_vld_q;
  logic [CHAR_W-1:0]       rdata_q;
  logic                    rvld_q;
  req_t                    req_q;

  always_ff @(posedge clk_i) begin
    if (lt_we_i) begin
      lt_mem[lt_waddr_i] <= lt_wdata_i;
    end
    rdata_q <= lt_mem[lt_raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_vld_q <= '0;
      rvld_q   <= 1'b0;
      req_q    <= '0;
    end else begin
      if (lt_we_i) begin
        lt_vld_q[lt_waddr_i] <= 1'b1;
      end
      rvld_q <= lt_vld_q[lt_raddr_i];
      req_q  <= req_i;
    end
  end

  assign req_o  = req_q;
  assign char_o = !req_q.show_long ? req_q.short_char :
                  (req_q.in_range && rvld_q) ? rdata_q : SPACE_CODE;

endmodule

`default_nettype wire

// ----- hw/rtl/sdmps_font.sv -----
// Font memory (256 segment words) and the result register for each fast tick.
// Uses sdmps_pkg. Fed by the stage that resolved the displayed character.
`default_nettype none

module sdmps_font import sdmps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire req_t              req_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output logic                   out_valid_o,
  output out_t                   out_o
);

  logic [DATA_W-1:0] font_mem [256];
  logic [DATA_W-1:0] font_q;
  logic              tick_q;
  logic              load_q, mask_sel_q;
  logic [DATA_W-1:0] mask_word_q;
  logic [EN_W-1:0]   en_q;

  always_ff @(posedge clk_i) begin
    if (req_i.font_we) begin
      font_mem[req_i.font_addr] <= req_i.font_data;
    end
    font_q      <= font_mem[char_i];
    load_q      <= req_i.load;
    mask_sel_q  <= req_i.mask_sel;
    mask_word_q <= req_i.mask_word;
    en_q        <= req_i.enables;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 1'b0;
    end else begin
      tick_q <= req_i.tick;
    end
  end

  assign out_valid_o   = tick_q;
  assign out_o.enables = en_q;
  assign out_o.load    = load_q;
  assign out_o.word    = !load_q ? '0 : (mask_sel_q ? mask_word_q : font_q);

endmodule

`default_nettype wire

// ----- hw/rtl/sdmps_ofifo.sv -----
// Result queue between the lookup pipeline and the output stream.
// Uses sdmps_pkg for the result type and depth.
`default_nettype none

module sdmps_ofifo import sdmps_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire out_t                   data_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output out_t                        data_o,
  output logic [OFIFO_CNT_W-1:0]      count_o
);

  out_t                   mem_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_q, rd_q;
  logic [OFIFO_CNT_W-1:0] cnt_q;
  logic                   do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + OFIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + OFIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + OFIFO_CNT_W'(push_i) - OFIFO_CNT_W'(do_pop);
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ----- tb/tb_display_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the multiplexed segment display driver: watches the item, result
// and register channels, predicts every fast-tick result and compares it. Uses sdmps_pkg.
module tb_display_checker import sdmps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  logic                 item_ready_i,
  input  logic [23:0]          item_data_i,
  input  logic [OP_W-1:0]      item_op_i,
  input  logic                 frame_valid_i,
  input  logic                 frame_ready_i,
  input  logic [23:0]          frame_data_i,
  input  logic [0:0]           frame_load_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int unsigned          frames_due_o,
  output int unsigned          fails_o
);

  localparam int DIGIT_N = 2;
  localparam int TEXT_N  = 64;

  // register copies
  logic [15:0] bright;
  logic        blink_on;
  logic [15:0] fade_inc;
  logic [9:0]  step_dly;
  logic [9:0]  pre_dly;

  // display state
  logic        pos;
  logic [5:0]  phase;
  logic [5:0]  duty;
  logic [1:0]  redraw;
  logic [7:0]  blink_cnt;
  logic [15:0] fade_cnt;
  logic        scrolling;
  logic [6:0]  offset;
  logic [9:0]  step_tmr;
  logic [9:0]  pre_tmr;
  logic [6:0]  long_len;
  logic        show_long;
  logic        mask_on;
  logic [1:0]  lit;
  logic [7:0]  short_chars [DIGIT_N];
  logic [7:0]  long_chars [TEXT_N];
  logic [15:0] masks [DIGIT_N];
  logic [15:0] glyphs [256];

  out_t        frames_due [$];
  int unsigned fail_cnt;

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (cfg_e'(idx))
      CFG_BRIGHTNESS: bright = data;
      CFG_BLINK:      blink_on = data[0];
      CFG_FADE_STEP:  fade_inc = data;
      CFG_STEP_DELAY: step_dly = data[9:0];
      CFG_PRE_DELAY:  pre_dly = data[9:0];
      default: ;
    endcase
  endfunction

  function automatic void slow_tick();
    int unsigned level;
    if (scrolling) begin
      if (pre_tmr != '0) begin
        pre_tmr = pre_tmr - 1'b1;
      end else begin
        step_tmr = step_tmr - 1'b1;  // wraps, so a zero delay means 1024 ticks
        if (step_tmr == '0) begin
          offset = offset + 1'b1;
          if (int'(offset) > int'(long_len) - DIGIT_N + 1) scrolling = 1'b0;
          step_tmr = step_dly;
        end
      end
    end
    show_long = scrolling && pre_tmr == '0;
    if (fade_inc != '0) begin
      fade_cnt = fade_cnt + fade_inc;
      level = (fade_cnt >> 1) + (fade_cnt >> 2) + 16384;
    end else begin
      level = bright;
    end
    level = 2048 + 31 * (level >> 5);
    duty = 6'(level >> 10);
    blink_cnt = blink_cnt + 1'b1;
    redraw = '1;
  endfunction

  function automatic out_t fast_tick();
    out_t        frame;
    logic [7:0]  ch;
    int unsigned at;
    frame = '0;
    if (phase == '0) begin
      lit[pos] = 1'b0;
      pos = pos + 1'b1;
      redraw[pos] = 1'b1;
    end else if (phase - 6'd1 == duty) begin
      redraw[pos] = 1'b1;
    end
    if (redraw[pos]) begin
      redraw[pos] = 1'b0;
      if (phase <= duty && (!blink_on || blink_cnt < BLINK_HALF)) begin
        if (mask_on) begin
          frame.word = masks[pos];
        end else begin
          at = offset + pos;
          if (!show_long) ch = short_chars[pos];
          else if (at < TEXT_N) ch = long_chars[at];
          else ch = SPACE_CODE;  // scrolled past the end of the text memory
          frame.word = glyphs[ch];
        end
        frame.load = 1'b1;
        lit[pos] = 1'b1;
      end else begin
        lit[pos] = 1'b0;
      end
    end
    phase = phase + 1'b1;
    frame.enables = lit;
    return frame;
  endfunction

  function automatic void take_item(op_e op, logic [7:0] idx, logic [15:0] val);
    case (op)
      OP_FAST_TICK:  frames_due.push_back(fast_tick());
      OP_SLOW_TICK:  slow_tick();
      OP_SHORT_CHAR: if (idx < DIGIT_N) short_chars[idx[0]] = val[7:0];
      OP_LONG_CHAR:  if (idx < TEXT_N) long_chars[idx[5:0]] = val[7:0];
      OP_COMMIT: begin
        long_len = (val < TEXT_N) ? val[6:0] : 7'(TEXT_N);
        scrolling = 1'b0;
        mask_on = 1'b0;
      end
      OP_SCROLL: begin
        if (long_len > DIGIT_N) begin
          scrolling = 1'b1;
          offset = '0;
          step_tmr = step_dly;
          pre_tmr = pre_dly;
        end
      end
      OP_MASK_WORD: begin
        if (idx < DIGIT_N) begin
          masks[idx[0]] = val;
          mask_on = 1'b1;
        end
      end
      default: glyphs[idx] = val;
    endcase
  endfunction

  function automatic void report(string field, int unsigned want, int unsigned got);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function automatic void check_frame(out_t got);
    out_t want;
    if (frames_due.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      return;
    end
    want = frames_due.pop_front();
    if (got.enables !== want.enables) report("digit_enables", want.enables, got.enables);
    if (got.load !== want.load) report("segment_load", want.load, got.load);
    if (got.word !== want.word) report("segment_word", want.word, got.word);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright    = BRIGHT_RST;
      blink_on  = 1'b0;
      fade_inc  = '0;
      step_dly  = STEP_DELAY_RST;
      pre_dly   = PRE_DELAY_RST;
      pos       = 1'b0;
      phase     = '0;
      duty      = '0;
      redraw    = '0;
      blink_cnt = '0;
      fade_cnt  = '0;
      scrolling = 1'b0;
      offset    = '0;
      step_tmr  = '0;
      pre_tmr   = '0;
      long_len  = '0;
      show_long = 1'b0;
      mask_on   = 1'b0;
      lit       = '0;
      for (int i = 0; i < DIGIT_N; i++) begin
        short_chars[i] = SPACE_CODE;
        masks[i] = '0;
      end
      for (int i = 0; i < TEXT_N; i++) long_chars[i] = SPACE_CODE;
      for (int i = 0; i < 256; i++) glyphs[i] = '0;
      frames_due.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (frame_valid_i && frame_ready_i)
        check_frame('{enables: frame_data_i[1:0], load: frame_load_i[0],
                      word: frame_data_i[17:2]});
      if (item_valid_i && item_ready_i)
        take_item(op_e'(item_op_i), item_data_i[7:0], item_data_i[23:8]);
    end
    frames_due_o <= frames_due.size();
    fails_o <= fail_cnt;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the multiplexed segment display driver: clock, reset, stimulus
// and verdict. Uses sdmps_pkg, segment_display_mux_pwm_scroll and tb_display_checker.
module tb_top;
  import sdmps_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;  // [7:0] index, [23:8] value
  logic [OP_W-1:0]      s_axis_tuser = '0;  // [2:0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [23:0]          m_axis_tdata;       // [1:0] digit_enables, [17:2] segment_word
  logic [0:0]           m_axis_tuser;       // [0] segment_load
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  int unsigned frames_due;
  int unsigned fails;
  bit          calm = 1'b0;  // no idling on either side while set

  segment_display_mux_pwm_scroll u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tb_display_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_i  (s_axis_tready),
    .item_data_i   (s_axis_tdata),
    .item_op_i     (s_axis_tuser),
    .frame_valid_i (m_axis_tvalid),
    .frame_ready_i (m_axis_tready),
    .frame_data_i  (m_axis_tdata),
    .frame_load_i  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .frames_due_o  (frames_due),
    .fails_o       (fails)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one transfer on the item channel, with random gaps ahead of it unless calm is set
  task automatic send_item(input op_e op, input logic [7:0] idx, input logic [15:0] val);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // hold the input until every result is in, then give the pipe time to settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [15:0] bright, input logic blink,
                          input logic [15:0] fade, input logic [9:0] step_dly,
                          input logic [9:0] pre_dly);
    drain();
    write_reg(CFG_BRIGHTNESS, bright);
    write_reg(CFG_BLINK, {15'd0, blink});
    write_reg(CFG_FADE_STEP, fade);
    write_reg(CFG_STEP_DELAY, {6'd0, step_dly});
    write_reg(CFG_PRE_DELAY, {6'd0, pre_dly});
    cfg_valid_i <= 1'b0;
  endtask

  // mostly in range, now and then any index
  function automatic logic [7:0] pick_idx(input int span);
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1));
  endfunction

  task automatic load_scroll(input logic [15:0] len);
    send_item(OP_COMMIT, 8'($urandom), len);
    repeat ($urandom_range(2, 8))
      send_item(OP_LONG_CHAR, 8'($urandom_range(0, 63)), 16'($urandom));
    send_item(OP_SCROLL, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_write();
    int r;
    r = $urandom_range(0, 27);
    if (r < 4)
      send_item(OP_SHORT_CHAR, pick_idx(2), 16'($urandom));
    else if (r < 12)
      send_item(OP_LONG_CHAR, pick_idx(64), 16'($urandom));
    else if (r < 16)
      send_item(OP_COMMIT, 8'($urandom), ($urandom_range(0, 7) == 0) ?
                16'($urandom) : 16'($urandom_range(0, 70)));
    else if (r < 20)
      send_item(OP_SCROLL, 8'($urandom), 16'($urandom));
    else if (r < 22)
      send_item(OP_MASK_WORD, pick_idx(2), 16'($urandom));
    else
      send_item(OP_FONT_ENTRY, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_mix(input int n, input int slow_pct, input int write_pct);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < slow_pct) send_item(OP_SLOW_TICK, 8'($urandom), 16'($urandom));
      else if (r < slow_pct + write_pct) send_write();
      else send_item(OP_FAST_TICK, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    set_mode(16'hFFFF, 1'b0, 16'd0, 10'd1, 10'd0);

    // every glyph and both mask words are defined before the first lookup
    for (int c = 0; c < 256; c++) send_item(OP_FONT_ENTRY, 8'(c), 16'($urandom));
    send_item(OP_MASK_WORD, 8'd0, 16'($urandom));
    send_item(OP_MASK_WORD, 8'd1, 16'($urandom));
    send_item(OP_COMMIT, 8'd0, 16'd0);

    // directed: duty still zero, so a rising and a falling edge come at once
    send_item(OP_FAST_TICK, 8'hFF, 16'hFFFF);
    send_item(OP_FAST_TICK, 8'h00, 16'h0000);
    send_item(OP_SHORT_CHAR, 8'd0, 16'hFF41);
    send_item(OP_SHORT_CHAR, 8'd1, 16'h007E);
    send_item(OP_SHORT_CHAR, 8'd2, 16'h0030);
    send_item(OP_SHORT_CHAR, 8'hFF, 16'hFFFF);
    send_item(OP_LONG_CHAR, 8'd0, 16'h0042);
    send_item(OP_LONG_CHAR, 8'd63, 16'hFFFF);
    send_item(OP_LONG_CHAR, 8'd64, 16'h0001);
    send_item(OP_LONG_CHAR, 8'hFF, 16'h0000);
    send_item(OP_FONT_ENTRY, 8'hFF, 16'hFFFF);
    send_item(OP_FONT_ENTRY, 8'h00, 16'h0000);
    send_item(OP_COMMIT, 8'd0, 16'd2);      // too short to scroll
    send_item(OP_SCROLL, 8'd0, 16'd0);
    send_item(OP_COMMIT, 8'd0, 16'hFFFF);   // clamps to the text size
    send_item(OP_SCROLL, 8'hFF, 16'hFFFF);
    send_item(OP_SLOW_TICK, 8'd0, 16'd0);
    send_item(OP_FAST_TICK, 8'd0, 16'd0);
    send_item(OP_SLOW_TICK, 8'hFF, 16'hFFFF);
    send_item(OP_MASK_WORD, 8'd2, 16'h1234);
    send_item(OP_MASK_WORD, 8'd1, 16'hFFFF);
    send_item(OP_FAST_TICK, 8'd0, 16'd0);
    send_item(OP_MASK_WORD, 8'd0, 16'h0000);
    send_item(OP_COMMIT, 8'd0, 16'd3);
    send_item(OP_FAST_TICK, 8'd0, 16'd0);

    calm = 1'b1;
    set_mode(16'hFFFF, 1'b0, 16'd0, 10'd1, 10'd0);
    load_scroll(16'd6);
    run_mix(250, 20, 25);
    calm = 1'b0;

    set_mode(16'h0000, 1'b0, 16'd0, 10'd2, 10'd3);
    load_scroll(16'd12);
    run_mix(200, 15, 25);

    // a zero step delay stretches each scroll step to 1024 slow ticks
    set_mode(16'd30000, 1'b1, 16'd0, 10'd0, 10'd1);
    load_scroll(16'd40);
    run_mix(200, 25, 20);

    // full-length text, scrolled past its end while fading
    set_mode(16'hFFFF, 1'b1, 16'hFFFF, 10'd1, 10'd0);
    load_scroll(16'd200);
    run_mix(300, 35, 3);

    set_mode(16'd12345, 1'b0, 16'd1, 10'd1023, 10'd1023);
    load_scroll(16'd64);
    run_mix(150, 10, 30);

    set_mode(16'($urandom), 1'($urandom), 16'($urandom), 10'($urandom_range(0, 1023)),
             10'($urandom_range(0, 7)));
    load_scroll(16'($urandom_range(3, 64)));
    run_mix(200, 15, 25);

    set_mode(16'hFFFF, 1'b0, 16'd0, 10'd3, 10'd2);
    load_scroll(16'd3);
    run_mix(200, 20, 25);

    drain();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sdmps_pkg.sv
hw/rtl/sdmps_ctrl.sv
hw/rtl/sdmps_text.sv
hw/rtl/sdmps_font.sv
hw/rtl/sdmps_ofifo.sv
hw/rtl/segment_display_mux_pwm_scroll.sv
tb/tb_display_checker.sv
tb/tb_top.sv
